// ===== rtl/btc_pkg.sv =====
// Shared types and constants of the barometric temperature compensation block.
// No dependencies; every other file in rtl imports this package.
package btc_pkg;

    localparam int ADC_W     = 20;
    localparam int CAL_W     = 32;
    localparam int NUM_CAL   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_W    = 64;

    // Register stages: front end, one per quotient bit, back end.
    localparam int N_FRONT = 12;
    localparam int N_DIV   = WORD_W;
    localparam int N_POST  = 6;
    localparam int N_STAGE = N_FRONT + N_DIV + N_POST;

    localparam logic signed [32:0] OFFSET_T_FINE = 33'sd128000;
    localparam logic [20:0]        PRESS_FULL    = 21'd1048576;
    localparam logic [11:0]        PRESS_SCALE   = 12'd3125;
    localparam logic [31:0]        ROUND_TEMP    = 32'd128;
    localparam int                 ONE_SHIFT     = 47;
    localparam int                 DIV_SHIFT     = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_T1_T2 = 3'd0,
        CFG_T3_P1 = 3'd1,
        CFG_P2_P3 = 3'd2,
        CFG_P4_P5 = 3'd3,
        CFG_P6_P7 = 3'd4,
        CFG_P8_P9 = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_valid;
    } t_result;

    typedef struct packed {
        logic [WORD_W-1:0]  rem;
        logic [WORD_W-1:0]  quo;
        logic [WORD_W-1:0]  md;
        logic               neg;
        logic               zero;
        logic signed [31:0] temp;
    } t_div_stage;

endpackage

// ===== rtl/btc_if.sv =====
// Channel interfaces of the compensation block: sample in, result out, calibration writes.
// Depends on btc_pkg.
interface btc_sample_if;
    import btc_pkg::*;
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_temperature;
    logic [ADC_W-1:0] adc_pressure;
    modport source(output valid, output adc_temperature, output adc_pressure, input ready);
    modport sink(input valid, input adc_temperature, input adc_pressure, output ready);
endinterface

interface btc_result_if;
    import btc_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
    modport source(output valid, output temperature_centi, output pressure_q24_8,
                   output pressure_valid, input ready);
    modport sink(input valid, input temperature_centi, input pressure_q24_8,
                 input pressure_valid, output ready);
endinterface

interface btc_cfg_if;
    import btc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CAL_W-1:0]     data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/baro_temp_compensation.sv =====
// Barometric temperature and pressure compensation, fully pipelined.
// Depends on btc_pkg and the interfaces in btc_if.
//
//   channel    dir  beat contents
//   i_sample   in   adc_temperature, adc_pressure
//   o_result   out  temperature_centi, pressure_q24_8, pressure_valid
//   i_cfg      in   index, data (calibration word pair)
//
// One sample enters per cycle while the skid register is empty; the stages are 12 front stages,
// 64 divider stages (one quotient bit each), 6 back stages, output register.
// The 64-stage restoring divider sets the depth of the pipeline.
// i_rst_n is synchronous; it clears all valid bits and the calibration words.
// A one-beat skid register keeps input open as an output stall begins;
// the whole pipeline holds while the skid is full.
module baro_temp_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    btc_cfg_if.sink            i_cfg,
    btc_sample_if.sink         i_sample,
    btc_result_if.source       o_result
);
    import btc_pkg::*;

    logic [CAL_W-1:0] r_cal [NUM_CAL];

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = r_cal[CFG_T1_T2][15:0];
    assign t2 = $signed(r_cal[CFG_T1_T2][31:16]);
    assign t3 = $signed(r_cal[CFG_T3_P1][15:0]);
    assign p1 = r_cal[CFG_T3_P1][31:16];
    assign p2 = $signed(r_cal[CFG_P2_P3][15:0]);
    assign p3 = $signed(r_cal[CFG_P2_P3][31:16]);
    assign p4 = $signed(r_cal[CFG_P4_P5][15:0]);
    assign p5 = $signed(r_cal[CFG_P4_P5][31:16]);
    assign p6 = $signed(r_cal[CFG_P6_P7][15:0]);
    assign p7 = $signed(r_cal[CFG_P6_P7][31:16]);
    assign p8 = $signed(r_cal[CFG_P8_P9][15:0]);
    assign p9 = $signed(r_cal[CFG_P8_P9][31:16]);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CAL; i++) begin
                r_cal[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_T1_T2: r_cal[CFG_T1_T2] <= i_cfg.data;
                CFG_T3_P1: r_cal[CFG_T3_P1] <= i_cfg.data;
                CFG_P2_P3: r_cal[CFG_P2_P3] <= i_cfg.data;
                CFG_P4_P5: r_cal[CFG_P4_P5] <= i_cfg.data;
                CFG_P6_P7: r_cal[CFG_P6_P7] <= i_cfg.data;
                CFG_P8_P9: r_cal[CFG_P8_P9] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic               r_sv, r_ov;
    t_result            r_sd, r_od;
    logic [N_STAGE-1:0] r_vld;
    logic               en, in_acc, last_v, out_take;
    t_result            res_c;

    assign en       = !r_sv;
    assign in_acc   = i_sample.valid & en;
    assign last_v   = r_vld[N_STAGE-1] & en;
    assign out_take = o_result.ready | !r_ov;
    assign i_sample.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
            r_sv  <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[N_STAGE-2:0], in_acc};
            end
            if (out_take) begin
                if (r_sv) begin
                    r_ov <= 1'b1;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= last_v;
                end
            end else if (last_v) begin
                r_sv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_od <= r_sv ? r_sd : res_c;
        end else if (last_v) begin
            r_sd <= res_c;
        end
    end

    assign o_result.valid             = r_ov;
    assign o_result.temperature_centi = r_od.temperature_centi;
    assign o_result.pressure_q24_8    = r_od.pressure_q24_8;
    assign o_result.pressure_valid    = r_od.pressure_valid;

    // ---------------- datapath registers ----------------
    logic signed [17:0] r_s1_dt1;
    logic signed [16:0] r_s1_dt2;
    logic [31:0]        r_s2_ma, r_s2_dsq;
    logic signed [31:0] r_s3_a;
    logic [31:0]        r_s3_mb;
    logic signed [31:0] r_s4_tf;
    logic signed [32:0] r_s5_v1;
    logic [63:0]        r_s6_vsq;
    logic signed [48:0] r_s6_v1p5, r_s6_v1p2;
    logic signed [48:0] r_s7_a6l, r_s7_a3l, r_s7_v1p5, r_s7_v1p2;
    logic [31:0]        r_s7_a6h, r_s7_a3h;
    logic [63:0]        r_s8_v2, r_s8_v1b;
    logic [63:0]        r_s9_x, r_s9_nd;
    logic [47:0]        r_s10_xl;
    logic [43:0]        r_s10_nl;
    logic [31:0]        r_s10_xh, r_s10_nh;
    logic [63:0]        r_s11_den, r_s11_num;
    logic [ADC_W-1:0]   r_adcp [8];
    logic signed [31:0] r_temp [5:12];
    logic               r_s12_neg, r_s12_zero;
    logic [63:0]        r_s12_mn, r_s12_md;
    t_div_stage         r_div [N_DIV];

    logic [63:0]        r_p1_p, r_p2_p, r_p2_pr, r_p3_p, r_p3_pr, r_p3_y, r_p3_r;
    logic signed [48:0] r_p2_b9l, r_p2_c8l;
    logic [31:0]        r_p2_b9h, r_p2_c8h;
    logic [63:0]        r_p4_m0, r_p4_p, r_p4_r;
    logic [31:0]        r_p4_m1, r_p4_m2;
    logic [63:0]        r_p5_q, r_p5_p, r_p5_r, r_p6_s;
    logic signed [31:0] r_ptemp [N_POST];
    logic               r_pzero [N_POST];

    // ---------------- combinational stage logic ----------------
    logic signed [33:0] ma_full, dsq_full;
    logic signed [19:0] bq;
    logic signed [35:0] mb_full;
    logic signed [31:0] tf, tf5;
    logic signed [63:0] vsq_full;
    logic signed [48:0] v1p5_full, v1p2_full, a6l, a3l;
    logic [31:0]        a6h, a3h;
    logic [63:0]        v2_c, t3prod, v1b_c;
    logic [20:0]        pdiff;
    logic [47:0]        xl;
    logic [43:0]        nl;
    logic [31:0]        xh, nh;
    logic [63:0]        xp;
    t_div_stage         div_n [N_DIV];
    t_div_stage         div_in [N_DIV];
    logic [63:0]        div_sh [N_DIV];
    logic [63:0]        pr_c;
    logic signed [48:0] b9l, c8l;
    logic [31:0]        b9h, c8h;
    logic [63:0]        r8_sum, p9pr;
    logic [63:0]        m0;
    logic [31:0]        m1, m2;
    logic [63:0]        ssum, s_c;

    always_comb begin
        ma_full  = r_s1_dt1 * t2;
        dsq_full = r_s1_dt2 * r_s1_dt2;
        bq       = 20'($signed(r_s2_dsq) >>> 12);
        mb_full  = bq * t3;
        tf       = r_s3_a + ($signed(r_s3_mb) >>> 14);
        tf5      = (r_s4_tf <<< 2) + r_s4_tf + $signed(ROUND_TEMP);

        vsq_full  = r_s5_v1 * r_s5_v1;
        v1p5_full = r_s5_v1 * p5;
        v1p2_full = r_s5_v1 * p2;

        // 64 x 16 products modulo 2^64 as two partial products.
        a6l = $signed({1'b0, r_s6_vsq[31:0]}) * p6;
        a6h = r_s6_vsq[63:32] * {{16{p6[15]}}, p6};
        a3l = $signed({1'b0, r_s6_vsq[31:0]}) * p3;
        a3h = r_s6_vsq[63:32] * {{16{p3[15]}}, p3};

        v2_c   = {{15{r_s7_a6l[48]}}, r_s7_a6l} + {r_s7_a6h, 32'b0}
               + ({{15{r_s7_v1p5[48]}}, r_s7_v1p5} << 17)
               + ({{48{p4[15]}}, p4} << 35);
        t3prod = {{15{r_s7_a3l[48]}}, r_s7_a3l} + {r_s7_a3h, 32'b0};
        v1b_c  = 64'($signed(t3prod) >>> 8) + ({{15{r_s7_v1p2[48]}}, r_s7_v1p2} << 12);

        pdiff = PRESS_FULL - {1'b0, r_adcp[7]};

        xl = r_s9_x[31:0] * p1;
        xh = r_s9_x[63:32] * {16'b0, p1};
        nl = r_s9_nd[31:0] * PRESS_SCALE;
        nh = r_s9_nd[63:32] * {20'b0, PRESS_SCALE};
        xp = {16'b0, r_s10_xl} + {r_s10_xh, 32'b0};

        // Restoring divider, one quotient bit per stage.
        for (int k = 0; k < N_DIV; k++) begin
            if (k == 0) begin
                div_in[k].rem  = '0;
                div_in[k].quo  = r_s12_mn;
                div_in[k].md   = r_s12_md;
                div_in[k].neg  = r_s12_neg;
                div_in[k].zero = r_s12_zero;
                div_in[k].temp = r_temp[12];
            end else begin
                div_in[k] = r_div[k-1];
            end
            div_n[k]  = div_in[k];
            div_sh[k] = {div_in[k].rem[62:0], div_in[k].quo[63]};
            if (div_sh[k] >= div_in[k].md) begin
                div_n[k].rem = div_sh[k] - div_in[k].md;
                div_n[k].quo = {div_in[k].quo[62:0], 1'b1};
            end else begin
                div_n[k].rem = div_sh[k];
                div_n[k].quo = {div_in[k].quo[62:0], 1'b0};
            end
        end

        pr_c = 64'($signed(r_p1_p) >>> 13);
        b9l  = $signed({1'b0, pr_c[31:0]}) * p9;
        b9h  = pr_c[63:32] * {{16{p9[15]}}, p9};
        c8l  = $signed({1'b0, r_p1_p[31:0]}) * p8;
        c8h  = r_p1_p[63:32] * {{16{p8[15]}}, p8};

        p9pr   = {{15{r_p2_b9l[48]}}, r_p2_b9l} + {r_p2_b9h, 32'b0};
        r8_sum = {{15{r_p2_c8l[48]}}, r_p2_c8l} + {r_p2_c8h, 32'b0};

        m0 = r_p3_y[31:0] * r_p3_pr[31:0];
        m1 = r_p3_y[31:0] * r_p3_pr[63:32];
        m2 = r_p3_y[63:32] * r_p3_pr[31:0];

        ssum = r_p5_p + r_p5_q + r_p5_r;
        s_c  = 64'($signed(ssum) >>> 8) + ({{48{p7[15]}}, p7} << 4);

        res_c.temperature_centi = r_ptemp[N_POST-1];
        if (r_pzero[N_POST-1]) begin
            res_c.pressure_q24_8 = '0;
            res_c.pressure_valid = 1'b0;
        end else begin
            res_c.pressure_valid = 1'b1;
            if (r_p6_s[63]) begin
                res_c.pressure_q24_8 = '0;
            end else if (r_p6_s[63:32] != '0) begin
                res_c.pressure_q24_8 = '1;
            end else begin
                res_c.pressure_q24_8 = r_p6_s[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // temperature
            r_s1_dt1  <= $signed({1'b0, i_sample.adc_temperature[19:3]})
                       - $signed({1'b0, t1, 1'b0});
            r_s1_dt2  <= $signed({1'b0, i_sample.adc_temperature[19:4]}) - $signed({1'b0, t1});
            r_adcp[0] <= i_sample.adc_pressure;
            for (int i = 1; i < 8; i++) begin
                r_adcp[i] <= r_adcp[i-1];
            end
            r_s2_ma  <= ma_full[31:0];
            r_s2_dsq <= dsq_full[31:0];
            r_s3_a   <= $signed(r_s2_ma) >>> 11;
            r_s3_mb  <= mb_full[31:0];
            r_s4_tf  <= tf;
            r_temp[5] <= tf5 >>> 8;
            r_s5_v1  <= {r_s4_tf[31], r_s4_tf} - OFFSET_T_FINE;
            for (int i = 6; i <= 12; i++) begin
                r_temp[i] <= r_temp[i-1];
            end

            // pressure, front end
            r_s6_vsq  <= vsq_full;
            r_s6_v1p5 <= v1p5_full;
            r_s6_v1p2 <= v1p2_full;
            r_s7_a6l  <= a6l;
            r_s7_a6h  <= a6h;
            r_s7_a3l  <= a3l;
            r_s7_a3h  <= a3h;
            r_s7_v1p5 <= r_s6_v1p5;
            r_s7_v1p2 <= r_s6_v1p2;
            r_s8_v2   <= v2_c;
            r_s8_v1b  <= v1b_c;
            r_s9_x    <= r_s8_v1b + (64'd1 << ONE_SHIFT);
            r_s9_nd   <= ({43'b0, pdiff} << 31) - r_s8_v2;
            r_s10_xl  <= xl;
            r_s10_xh  <= xh;
            r_s10_nl  <= nl;
            r_s10_nh  <= nh;
            r_s11_den <= 64'($signed(xp) >>> DIV_SHIFT);
            r_s11_num <= {20'b0, r_s10_nl} + {r_s10_nh, 32'b0};
            r_s12_neg  <= r_s11_num[63] ^ r_s11_den[63];
            r_s12_mn   <= r_s11_num[63] ? (64'd0 - r_s11_num) : r_s11_num;
            r_s12_md   <= r_s11_den[63] ? (64'd0 - r_s11_den) : r_s11_den;
            r_s12_zero <= (r_s11_den == '0);

            for (int k = 0; k < N_DIV; k++) begin
                r_div[k] <= div_n[k];
            end

            // pressure, back end
            r_p1_p     <= r_div[N_DIV-1].neg ? (64'd0 - r_div[N_DIV-1].quo)
                                             : r_div[N_DIV-1].quo;
            r_ptemp[0] <= r_div[N_DIV-1].temp;
            r_pzero[0] <= r_div[N_DIV-1].zero;
            for (int i = 1; i < N_POST; i++) begin
                r_ptemp[i] <= r_ptemp[i-1];
                r_pzero[i] <= r_pzero[i-1];
            end
            r_p2_p   <= r_p1_p;
            r_p2_pr  <= pr_c;
            r_p2_b9l <= b9l;
            r_p2_b9h <= b9h;
            r_p2_c8l <= c8l;
            r_p2_c8h <= c8h;
            r_p3_p   <= r_p2_p;
            r_p3_pr  <= r_p2_pr;
            r_p3_y   <= p9pr;
            r_p3_r   <= 64'($signed(r8_sum) >>> 19);
            r_p4_m0  <= m0;
            r_p4_m1  <= m1;
            r_p4_m2  <= m2;
            r_p4_p   <= r_p3_p;
            r_p4_r   <= r_p3_r;
            r_p5_q   <= 64'($signed(r_p4_m0 + {r_p4_m1 + r_p4_m2, 32'b0}) >>> 25);
            r_p5_p   <= r_p4_p;
            r_p5_r   <= r_p4_r;
            r_p6_s   <= s_c;
        end
    end

endmodule

// ===== rtl/btc_checker.sv =====
// Port-level checks of baro_temp_compensation, attached by the bind below.
// Depends on btc_pkg and on the top level's ports.
module btc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_temp,
    input logic [31:0] i_out_press,
    input logic        i_out_pvalid
);
    import btc_pkg::*;

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_temp) && $stable(i_out_press)
             && $stable(i_out_pvalid)))
        else $error("result beat changed while stalled");

    // A zero divisor always reports pressure zero.
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_pvalid) |-> (i_out_press == '0))
        else $error("invalid pressure is not zero");

    // Input closes only after the output stalled in the previous cycle.
    a_in_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_in_ready && !$past(!i_rst_n)) |-> $past(i_out_valid && !i_out_ready))
        else $error("input closed without output stall");

    // Nothing comes out right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind baro_temp_compensation btc_checker u_btc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_sample.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_temp   (o_result.temperature_centi),
    .i_out_press  (o_result.pressure_q24_8),
    .i_out_pvalid (o_result.pressure_valid)
);
